// ----- rtl/core/srg_pkg.sv -----
// ----------------------------------------------------------------------------
// srg_pkg
// Shared types, constants and arithmetic for the subtractive lagged
// random generator (lags 55 and 24, modulo 10^9).
// ----------------------------------------------------------------------------
package srg_pkg;

  localparam int unsigned ValueW = 30;
  localparam int unsigned AddrW  = 6;
  localparam int unsigned PassW  = 4;
  localparam int unsigned Depth  = 56;

  typedef logic [ValueW-1:0] value_t;
  typedef logic [AddrW-1:0]  addr_t;
  typedef logic [PassW-1:0]  pass_t;

  localparam value_t Modulus      = 30'd1000000000;
  localparam value_t SeedReset    = 30'd234612947;
  localparam addr_t  TableLen     = 6'd55;
  localparam addr_t  ShortLag     = 6'd24;
  localparam addr_t  LagGap       = 6'd31;
  localparam addr_t  FillStride   = 6'd21;
  localparam pass_t  WarmupPasses = 4'd10;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED,
    ST_REFILL,
    ST_FETCH,
    ST_DELIVER
  } srg_state_e;

  typedef struct packed {
    logic   en;
    addr_t  addr;
    value_t data;
  } srg_wr_t;

  typedef struct packed {
    addr_t addr_a;
    addr_t addr_b;
  } srg_rd_t;

  // Difference modulo 10^9 of two values that are already below 10^9.
  function automatic value_t sub_mod(value_t a, value_t b);
    value_t diff;
    diff = a - b;
    if (a < b) begin
      diff = diff + Modulus;
    end
    return diff;
  endfunction

endpackage

// ----- rtl/core/srg_table.sv -----
// ----------------------------------------------------------------------------
// srg_table
// Lag table storage: one write port and two read ports with registered
// read data.
// ----------------------------------------------------------------------------
module srg_table (
  input  logic            clk_i,
  input  srg_pkg::srg_wr_t wr_i,
  input  srg_pkg::srg_rd_t rd_i,
  output srg_pkg::value_t rd_a_o,
  output srg_pkg::value_t rd_b_o
);
  import srg_pkg::*;

  value_t mem [Depth];
  value_t rd_a_q;
  value_t rd_b_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_a_q <= mem[rd_i.addr_a];
    rd_b_q <= mem[rd_i.addr_b];
  end

  assign rd_a_o = rd_a_q;
  assign rd_b_o = rd_b_q;

endmodule

// ----- rtl/core/subtractive_random_generator_core.sv -----
// ----------------------------------------------------------------------------
// subtractive_random_generator_core
// Subtractive lagged generator (lags 55 and 24, modulo 10^9) built around
// a 56-word table memory that is read, updated and written back in place.
//
//   Channel  Direction  Handshake               Payload
//   in       input      in_valid_i / in_ready_o draw_request_i
//   out      output     out_valid_o/out_ready_i random_value_o
//   cfg      input      cfg_we_i                cfg_wdata_i (seed)
//
// A draw steps through accept, table read, and load of the output
// register. Once every 55 draws, a draw first refills the table, one
// entry per cycle through the two read ports and the write port. The
// first draw after reset also seeds the table and runs ten refill
// passes. Reset leaves the table contents undefined; the output register
// lets the next item be accepted while a result still waits.
// ----------------------------------------------------------------------------
module subtractive_random_generator_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  srg_pkg::value_t cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            draw_request_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output srg_pkg::value_t random_value_o
);
  import srg_pkg::*;

  srg_state_e state_q, state_d;
  value_t     seed_q;
  addr_t      rp_q, rp_d;
  logic       seeded_q, seeded_d;
  addr_t      seed_cnt_q, seed_cnt_d;
  addr_t      pos_q, pos_d;
  value_t     prev_q, prev_d;
  value_t     cur_q, cur_d;
  addr_t      ref_idx_q, ref_idx_d;
  pass_t      passes_q, passes_d;
  logic       wr_valid_q, wr_valid_d;
  addr_t      wr_idx_q, wr_idx_d;
  logic       out_valid_q, out_valid_d;
  value_t     out_data_q, out_data_d;

  srg_wr_t    wr;
  srg_rd_t    rd;
  value_t     rd_a;
  value_t     rd_b;
  value_t     seed_red;
  logic [AddrW:0] pos_sum;
  addr_t      pos_next;

  srg_table u_table (
    .clk_i  (clk_i),
    .wr_i   (wr),
    .rd_i   (rd),
    .rd_a_o (rd_a),
    .rd_b_o (rd_b)
  );

  assign seed_red = (seed_q >= Modulus) ? (seed_q - Modulus) : seed_q;
  assign pos_sum  = {1'b0, pos_q} + {1'b0, FillStride};
  assign pos_next = (pos_sum >= {1'b0, TableLen}) ?
                    AddrW'(pos_sum - {1'b0, TableLen}) : AddrW'(pos_sum);

  always_comb begin
    state_d     = state_q;
    rp_d        = rp_q;
    seeded_d    = seeded_q;
    seed_cnt_d  = seed_cnt_q;
    pos_d       = pos_q;
    prev_d      = prev_q;
    cur_d       = cur_q;
    ref_idx_d   = ref_idx_q;
    passes_d    = passes_q;
    wr_valid_d  = 1'b0;
    wr_idx_d    = wr_idx_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    in_ready_o  = 1'b0;

    wr.en   = wr_valid_q;
    wr.addr = wr_idx_q;
    wr.data = sub_mod(rd_a, rd_b);

    rd.addr_a = rp_q;
    rd.addr_b = (ref_idx_q <= ShortLag) ? (ref_idx_q + LagGap) : (ref_idx_q - ShortLag);

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && draw_request_i) begin
          if (!seeded_q) begin
            state_d    = ST_SEED;
            seed_cnt_d = '0;
          end else if (rp_q == '0) begin
            state_d   = ST_REFILL;
            ref_idx_d = addr_t'(1);
            passes_d  = pass_t'(1);
          end else begin
            state_d = ST_FETCH;
          end
        end
      end
      ST_SEED: begin
        wr.en = 1'b1;
        if (seed_cnt_q == '0) begin
          wr.addr = TableLen;
          wr.data = seed_red;
          prev_d  = seed_red;
          cur_d   = value_t'(1);
          pos_d   = FillStride;
        end else begin
          wr.addr = pos_q;
          wr.data = cur_q;
          cur_d   = sub_mod(prev_q, cur_q);
          prev_d  = cur_q;
          pos_d   = pos_next;
        end
        seed_cnt_d = seed_cnt_q + addr_t'(1);
        if (seed_cnt_q == TableLen - addr_t'(1)) begin
          state_d   = ST_REFILL;
          ref_idx_d = addr_t'(1);
          passes_d  = WarmupPasses;
          seeded_d  = 1'b1;
        end
      end
      ST_REFILL: begin
        rd.addr_a  = ref_idx_q;
        wr_valid_d = 1'b1;
        wr_idx_d   = ref_idx_q;
        if (ref_idx_q == TableLen) begin
          ref_idx_d = addr_t'(1);
          if (passes_q == pass_t'(1)) begin
            state_d = ST_FETCH;
            rp_d    = TableLen;
          end else begin
            passes_d = passes_q - pass_t'(1);
          end
        end else begin
          ref_idx_d = ref_idx_q + addr_t'(1);
        end
      end
      ST_FETCH: begin
        // The last refill write must land before the entry is read.
        if (!wr_valid_q) begin
          state_d = ST_DELIVER;
        end
      end
      ST_DELIVER: begin
        if (!out_valid_q || out_ready_i) begin
          out_data_d  = rd_a;
          out_valid_d = 1'b1;
          rp_d        = rp_q - addr_t'(1);
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      seed_q      <= SeedReset;
      rp_q        <= TableLen;
      seeded_q    <= 1'b0;
      wr_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rp_q        <= rp_d;
      seeded_q    <= seeded_d;
      wr_valid_q  <= wr_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        seed_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    seed_cnt_q <= seed_cnt_d;
    pos_q      <= pos_d;
    prev_q     <= prev_d;
    cur_q      <= cur_d;
    ref_idx_q  <= ref_idx_d;
    passes_q   <= passes_d;
    wr_idx_q   <= wr_idx_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o    = out_valid_q;
  assign random_value_o = out_data_q;

endmodule
